// File: rtl/core/bm25ts_pkg.sv
// Shared types and constants of the BM25 term score core.
// Used by the log unit and the top level; depends on nothing.
`timescale 1ns / 1ps

package bm25ts_pkg;

    // Fraction bits of the log and tf values.
    localparam int LOG_FRAC = 20;
    // Width of the normalized mantissa in the log unit, Q1.31.
    localparam int MANT_W = 32;
    // ln(2) in Q0.32.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    // One in Q1.15 (b) and in Q4.12 (k1).
    localparam logic [15:0] B_ONE = 16'd32768;
    localparam logic [16:0] K1_ONE = 17'd4096;
    // Position of fdt in the denominator and shift of the tf numerator.
    localparam int K_SHIFT = 27;
    localparam int A_SHIFT = 15;
    // The tf quotient stays below 17.0, so five integer bits suffice.
    localparam int TF_INT_BITS = 5;
    localparam int TF_QUO_W = LOG_FRAC + TF_INT_BITS;
    // Output word: score in bits 31:0, status in bits 33:32.
    localparam int SCORE_W = 32;
    localparam int OUT_TDATA_W = 40;

    // Status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_ZERO_AVG = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // Configuration register indexes.
    typedef logic [3:0] t_cfg_index;
    localparam t_cfg_index CFG_DOC_COUNT = 4'd0;
    localparam t_cfg_index CFG_AVG_LENGTH = 4'd1;
    localparam t_cfg_index CFG_K1_GAIN = 4'd2;
    localparam t_cfg_index CFG_B_WEIGHT = 4'd3;

endpackage

// File: rtl/core/bm25ts_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used twice by bm25_term_score_core.
`timescale 1ns / 1ps

module bm25ts_div #(
    parameter int DEN_W = 32,
    parameter int QUO_W = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_rem,    // Starting remainder, below the divisor.
    input  logic [QUO_W-1:0]  i_low,    // Dividend bits shifted in, MSB first.
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid [0:QUO_W];
    logic [DEN_W-1:0]  r_rem   [0:QUO_W];
    logic [DEN_W-1:0]  r_den   [0:QUO_W];
    logic [QUO_W-1:0]  r_ql    [0:QUO_W];
    logic [SIDE_W-1:0] r_side  [0:QUO_W];

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_rem;
            r_den[0]  <= i_den;
            r_ql[0]   <= i_low;
            r_side[0] <= i_side;
        end
    end

    // One trial subtraction per stage; quotient bits enter where dividend bits leave.
    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic [DEN_W:0] n_trial;
        logic [DEN_W:0] n_diff;
        logic           n_bit;

        always_comb begin
            n_trial = {r_rem[s], r_ql[s][QUO_W-1]};
            n_diff  = n_trial - {1'b0, r_den[s]};
            n_bit   = (n_trial >= {1'b0, r_den[s]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_bit ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
                r_ql[s+1]   <= {r_ql[s][QUO_W-2:0], n_bit};
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_quo   = r_ql[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

// File: rtl/core/bm25ts_log2.sv
// Pipelined base-2 logarithm of two operands in parallel, Q.20, by repeated squaring.
// Depends on bm25ts_pkg for the fraction and mantissa widths.
`timescale 1ns / 1ps

module bm25ts_log2
    import bm25ts_pkg::*;
#(
    parameter int XW = 32,
    parameter int SIDE_W = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [XW-1:0]                    i_x_a,
    input  logic [XW-1:0]                    i_x_b,
    input  logic [SIDE_W-1:0]                i_side,
    output logic                             o_valid,
    output logic [$clog2(XW)+LOG_FRAC-1:0]   o_log_a,
    output logic [$clog2(XW)+LOG_FRAC-1:0]   o_log_b,
    output logic [SIDE_W-1:0]                o_side
);

    localparam int EW = $clog2(XW);
    localparam int LW = EW + LOG_FRAC;

    logic [XW-1:0]     n1_x [0:1];
    logic [EW-1:0]     n1_e [0:1];
    logic              r1_valid;
    logic [XW-1:0]     r1_x [0:1];
    logic [EW-1:0]     r1_e [0:1];
    logic [SIDE_W-1:0] r1_side;

    logic              r_valid [0:LOG_FRAC];
    logic [MANT_W-1:0] r_m     [0:LOG_FRAC][0:1];
    logic [LW-1:0]     r_acc   [0:LOG_FRAC][0:1];
    logic [SIDE_W-1:0] r_side  [0:LOG_FRAC];
    logic [XW+MANT_W-2:0] n2_wide [0:1];

    // Position of the leading one gives the integer part.
    always_comb begin
        n1_x[0] = i_x_a;
        n1_x[1] = i_x_b;
        for (int k = 0; k < 2; k++) begin
            n1_e[k] = '0;
            for (int j = 0; j < XW; j++) begin
                if (n1_x[k][j]) begin
                    n1_e[k] = EW'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r1_valid   <= i_valid;
            r_valid[0] <= r1_valid;
        end
    end

    // Normalize the operand to Q1.31 with the leading one at the top bit.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n2_wide[k] = {r1_x[k], {(MANT_W-1){1'b0}}} >> r1_e[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side   <= i_side;
            r_side[0] <= r1_side;
            for (int k = 0; k < 2; k++) begin
                r1_x[k]     <= n1_x[k];
                r1_e[k]     <= n1_e[k];
                r_m[0][k]   <= n2_wide[k][MANT_W-1:0];
                r_acc[0][k] <= {r1_e[k], {LOG_FRAC{1'b0}}};
            end
        end
    end

    // Each squaring yields one fraction bit, most significant first.
    for (genvar s = 0; s < LOG_FRAC; s++) begin : g_sq
        logic [2*MANT_W-1:0] n_sq  [0:1];
        logic [LW-1:0]       n_acc [0:1];
        logic [MANT_W-1:0]   n_m   [0:1];

        always_comb begin
            for (int k = 0; k < 2; k++) begin
                n_sq[k]  = r_m[s][k] * r_m[s][k];
                n_acc[k] = r_acc[s][k];
                n_acc[k][LOG_FRAC-1-s] = n_sq[k][2*MANT_W-1];
                n_m[k] = n_sq[k][2*MANT_W-1] ? n_sq[k][2*MANT_W-1:MANT_W]
                                             : n_sq[k][2*MANT_W-2:MANT_W-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                for (int k = 0; k < 2; k++) begin
                    r_m[s+1][k]   <= n_m[k];
                    r_acc[s+1][k] <= n_acc[k];
                end
            end
        end
    end

    assign o_valid = r_valid[LOG_FRAC];
    assign o_log_a = r_acc[LOG_FRAC][0];
    assign o_log_b = r_acc[LOG_FRAC][1];
    assign o_side  = r_side[LOG_FRAC];

endmodule

// File: rtl/core/bm25_term_score_core.sv
// Top level of the BM25 term score core: register file, pipeline stages and units.
// Depends on bm25ts_pkg, bm25ts_log2 and bm25ts_div.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one posting per word: doc_frequency, term_frequency and
// doc_length, each COUNT_WIDTH bits, packed from the lowest bit up. The master
// stream gives one result word per posting: a signed score with SCORE_FRAC_BITS
// fraction bits and a two-bit status (0 ok, 1 zero average length, 2 ft above N
// or zero denominator; the score is then zero).
// Registers doc_count, avg_doc_length, k1_gain and b_weight are written through
// the configuration channel, which is always ready; write them while no
// posting is in flight.
// A new posting can be accepted every cycle while the output is not held. The
// result of a posting passes stages A and B, the log unit, stages C and D, the
// normalization divider, stages E and F, the tf divider and stage G before the output
// register; the path holds the two bit-per-stage dividers and the twenty squaring stages of the log unit.
// When the receiver holds tready low with a result waiting, the whole pipeline
// holds and the slave tready falls in the same cycle; nothing is lost.
// Reset clears all valid bits and loads the register defaults
// (k1 = 1.2, b = 0.75, N and average length zero).
module bm25_term_score_core
    import bm25ts_pkg::*;
#(
    parameter int SCORE_FRAC_BITS = 16,
    parameter int COUNT_WIDTH = 31
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Postings in.
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // doc_frequency, term_frequency, doc_length from bit 0 up, zero padded.
    input  logic [((3*COUNT_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    // Scores out.
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // score (bits 31:0), status (bits 33:32), zero padded.
    output logic [OUT_TDATA_W-1:0]                 o_m_axis_tdata,
    // Configuration writes.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  t_cfg_index                             i_cfg_index,
    input  logic [31:0]                            i_cfg_data
);

    localparam int CW = COUNT_WIDTH;
    localparam int XW = CW + 1;
    localparam int LW = $clog2(XW) + LOG_FRAC;
    localparam int NUMW = CW + 15;
    localparam int DENW = CW + 32;
    localparam int PW = LW + TF_QUO_W;
    localparam int SH = 2 * LOG_FRAC - SCORE_FRAC_BITS;
    localparam logic [PW:0] RND = (PW + 1)'(1) << (SH - 1);

    typedef struct packed {
        t_status          status;
        logic [CW-1:0]    fdt;
        logic [NUMW-1:0]  num;
    } t_side_log;

    typedef struct packed {
        t_status          status;
        logic [CW-1:0]    fdt;
        logic             neg;
        logic [LW-1:0]    ln;
    } t_side_norm;

    typedef struct packed {
        t_status          status;
        logic             neg;
        logic [LW-1:0]    ln;
    } t_side_tf;

    logic              en;

    // Register file.
    logic [CW-1:0]     r_doc_count;
    logic [CW-1:0]     r_avg_len;
    logic [15:0]       r_k1;
    logic [15:0]       r_b;

    // Stage A: input word.
    logic              r_a_valid;
    logic [CW-1:0]     r_a_ft;
    logic [CW-1:0]     r_a_fdt;
    logic [CW-1:0]     r_a_dlen;

    // Stage B: checks, log operands and normalization numerator.
    logic [15:0]       n_b_bw;
    t_status           n_b_status;
    logic [NUMW-1:0]   n_b_num;
    logic              r_b_valid;
    t_side_log         r_b_side;
    logic [XW-1:0]     r_b_xa;
    logic [XW-1:0]     r_b_xb;

    // Log unit outputs.
    logic              w_log_valid;
    logic [LW-1:0]     w_log_a;
    logic [LW-1:0]     w_log_b;
    t_side_log         w_log_side;

    // Stage C: idf in log2 units.
    logic              r_c_valid;
    t_side_log         r_c_side;
    logic [LW-1:0]     r_c_d;
    logic              r_c_neg;

    // Stage D: idf in natural log units.
    logic [LW+31:0]    n_d_scaled;
    logic              r_d_valid;
    t_side_norm        r_d_side;
    logic [NUMW-1:0]   r_d_num;

    // Normalization divider outputs.
    logic              w_norm_valid;
    logic [NUMW-1:0]   w_norm;
    t_side_norm        w_norm_side;

    // Stage E: K term and tf numerator.
    logic [16:0]       n_e_k1p;
    logic              r_e_valid;
    t_side_norm        r_e_side;
    logic [DENW-1:0]   r_e_kq;
    logic [DENW-1:0]   r_e_a;

    // Stage F: tf denominator.
    logic [DENW-1:0]   n_f_den;
    logic              r_f_valid;
    t_side_tf          r_f_side;
    logic [DENW-1:0]   r_f_den;
    logic [DENW-1:0]   r_f_a;

    // tf divider outputs.
    logic              w_tf_valid;
    logic [TF_QUO_W-1:0] w_tf;
    t_side_tf          w_tf_side;

    // Stage G: product.
    logic              r_g_valid;
    t_side_tf          r_g_side;
    logic [PW-1:0]     r_g_prod;

    // Output register.
    logic [PW:0]       n_o_sum;
    logic [63:0]       n_o_mag;
    logic [SCORE_W-1:0] n_o_score;
    logic              r_o_valid;
    logic [SCORE_W-1:0] r_o_score;
    t_status           r_o_status;

    // The pipeline advances whenever the output register is free or being taken.
    assign en = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready = 1'b1;

    // Register writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_count <= '0;
            r_avg_len   <= '0;
            r_k1        <= 16'd4915;
            r_b         <= 16'd24576;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DOC_COUNT:  r_doc_count <= i_cfg_data[CW-1:0];
                CFG_AVG_LENGTH: r_avg_len   <= i_cfg_data[CW-1:0];
                CFG_K1_GAIN:    r_k1        <= i_cfg_data[15:0];
                CFG_B_WEIGHT:   r_b         <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the stages kept in this module.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_s_axis_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= w_log_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= w_norm_valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= w_tf_valid;
            r_o_valid <= r_g_valid;
        end
    end

    // Stage B logic: status checks and the weighted length sum.
    always_comb begin
        n_b_bw = (r_b > B_ONE) ? B_ONE : r_b;
        if (r_avg_len == '0) begin
            n_b_status = ST_ZERO_AVG;
        end else if (r_a_ft > r_doc_count) begin
            n_b_status = ST_RANGE;
        end else begin
            n_b_status = ST_OK;
        end
        n_b_num = NUMW'(B_ONE - n_b_bw) * NUMW'(r_avg_len)
                + NUMW'(n_b_bw) * NUMW'(r_a_dlen);
    end

    // Stage D logic: scale by ln(2) with rounding.
    assign n_d_scaled = (LW + 32)'(r_c_d) * (LW + 32)'(LN2_Q32) + (LW + 32)'(33'h0_8000_0000);

    // Stage E and F logic.
    assign n_e_k1p = {1'b0, r_k1} + K1_ONE;
    assign n_f_den = r_e_kq + (DENW'(r_e_side.fdt) << K_SHIFT);

    // Output logic: round to the score format and saturate, or give zero when the status is not ok.
    always_comb begin
        n_o_sum = {1'b0, r_g_prod} + RND;
        n_o_mag = 64'(n_o_sum >> SH);
        if (r_g_side.status != ST_OK) begin
            n_o_score = '0;
        end else if (r_g_side.neg) begin
            n_o_score = (n_o_mag > 64'h8000_0000) ? 32'h8000_0000
                                                   : (~n_o_mag[31:0] + 32'd1);
        end else begin
            n_o_score = (n_o_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : n_o_mag[31:0];
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage A.
            r_a_ft   <= i_s_axis_tdata[CW-1:0];
            r_a_fdt  <= i_s_axis_tdata[2*CW-1:CW];
            r_a_dlen <= i_s_axis_tdata[3*CW-1:2*CW];
            // Stage B.
            r_b_side.status <= n_b_status;
            r_b_side.fdt    <= r_a_fdt;
            r_b_side.num    <= n_b_num;
            r_b_xa <= {r_doc_count - r_a_ft, 1'b1};
            r_b_xb <= {r_a_ft, 1'b1};
            // Stage C.
            r_c_side <= w_log_side;
            r_c_neg  <= (w_log_a < w_log_b);
            r_c_d    <= (w_log_a >= w_log_b) ? (w_log_a - w_log_b) : (w_log_b - w_log_a);
            // Stage D.
            r_d_side.status <= r_c_side.status;
            r_d_side.fdt    <= r_c_side.fdt;
            r_d_side.neg    <= r_c_neg;
            r_d_side.ln     <= n_d_scaled[LW+31:32];
            r_d_num         <= r_c_side.num;
            // Stage E.
            r_e_side <= w_norm_side;
            r_e_kq   <= DENW'(r_k1) * DENW'(w_norm);
            r_e_a    <= (DENW'(n_e_k1p) * DENW'(w_norm_side.fdt)) << A_SHIFT;
            // Stage F.
            r_f_side.status <= (r_e_side.status == ST_OK && n_f_den == '0)
                               ? ST_RANGE : r_e_side.status;
            r_f_side.neg    <= r_e_side.neg;
            r_f_side.ln     <= r_e_side.ln;
            r_f_den         <= n_f_den;
            r_f_a           <= r_e_a;
            // Stage G.
            r_g_side <= w_tf_side;
            r_g_prod <= PW'(w_tf_side.ln) * PW'(w_tf);
            // Output.
            if (r_g_valid) begin
                r_o_score  <= n_o_score;
                r_o_status <= r_g_side.status;
            end
        end
    end

    // Logs of 2(N-ft)+1 and 2ft+1.
    bm25ts_log2 #(
        .XW     (XW),
        .SIDE_W ($bits(t_side_log))
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_x_a   (r_b_xa),
        .i_x_b   (r_b_xb),
        .i_side  (r_b_side),
        .o_valid (w_log_valid),
        .o_log_a (w_log_a),
        .o_log_b (w_log_b),
        .o_side  (w_log_side)
    );

    // Normalized length in Q.15: weighted sum over the average length.
    bm25ts_div #(
        .DEN_W  (CW),
        .QUO_W  (NUMW),
        .SIDE_W ($bits(t_side_norm))
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_valid),
        .i_rem   ('0),
        .i_low   (r_d_num),
        .i_den   (r_avg_len),
        .i_side  (r_d_side),
        .o_valid (w_norm_valid),
        .o_quo   (w_norm),
        .o_side  (w_norm_side)
    );

    // tf factor in Q.20; the quotient is known to fit its integer bits.
    bm25ts_div #(
        .DEN_W  (DENW),
        .QUO_W  (TF_QUO_W),
        .SIDE_W ($bits(t_side_tf))
    ) u_div_tf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_valid),
        .i_rem   (DENW'(r_f_a[DENW-1:TF_INT_BITS])),
        .i_low   ({r_f_a[TF_INT_BITS-1:0], {LOG_FRAC{1'b0}}}),
        .i_den   (r_f_den),
        .i_side  (r_f_side),
        .o_valid (w_tf_valid),
        .o_quo   (w_tf),
        .o_side  (w_tf_side)
    );

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-SCORE_W-2){1'b0}}, r_o_status, r_o_score};

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the BM25 term score core: directed and random postings
// checked against a bit-true score predictor. Depends on bm25ts_pkg and bm25_term_score_core.
`timescale 1ns / 1ps

module tb_top;
    import bm25ts_pkg::*;

    localparam int CW = 31;
    localparam int IN_W = ((3*CW+7)/8)*8;
    localparam longint unsigned CNT_MASK = (64'd1 << CW) - 1;
    localparam longint unsigned CNT_MAX = CNT_MASK;
    localparam int PIPE_DEPTH = CW + 72;
    // An index that decodes to no register.
    localparam t_cfg_index CFG_NONE = 4'd9;

    typedef struct packed {
        logic [31:0] score;
        t_status     status;
    } t_score_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    t_cfg_index i_cfg_index = CFG_DOC_COUNT;
    logic [31:0] i_cfg_data = '0;

    bm25_term_score_core dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor copy of the registers.
    longint unsigned n_docs, avg_len, k1_q12, b_q15;
    t_score_rec expected_scores[$];
    int mismatches = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;
    bit long_hold = 1'b0;

    // Base-2 log in Q.20 by repeated squaring of the normalized mantissa.
    function automatic longint unsigned log2_fixed(longint unsigned x);
        int e;
        longint unsigned m, acc;
        e = 0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
        acc = longint'(e) << 20;
        for (int i = 19; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                acc = acc | (64'd1 << i);
            end
        end
        return acc;
    endfunction

    function automatic t_score_rec bm25_score_of(longint unsigned ft, longint unsigned fdt,
                                                 longint unsigned dlen);
        t_score_rec res;
        longint unsigned b, num, norm, den, a, q, r, l1, l2, d, ln, mag;
        bit neg, top;
        b = (b_q15 > B_ONE) ? 64'(B_ONE) : b_q15;
        neg = 1'b0;
        mag = 0;
        res.status = ST_OK;
        if (avg_len == 0) begin
            res.status = ST_ZERO_AVG;
        end else if (ft > n_docs) begin
            res.status = ST_RANGE;
        end else begin
            num = (64'(B_ONE) - b) * avg_len + b * dlen;
            norm = num / avg_len;
            den = k1_q12 * norm + (fdt << 27);
            if (den == 0) begin
                res.status = ST_RANGE;
            end else begin
                // Tf factor by restoring division, 20 fraction bits.
                a = ((k1_q12 + 64'(K1_ONE)) * fdt) << 15;
                q = a / den;
                r = a % den;
                for (int i = 0; i < 20; i++) begin
                    top = r[63];
                    r = r << 1;
                    q = q << 1;
                    if (top || r >= den) begin
                        r = r - den;
                        q = q | 64'd1;
                    end
                end
                l1 = log2_fixed(2 * (n_docs - ft) + 1);
                l2 = log2_fixed(2 * ft + 1);
                if (l1 >= l2) begin
                    d = l1 - l2;
                end else begin
                    d = l2 - l1;
                    neg = 1'b1;
                end
                ln = (d * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
                mag = (ln * q + (64'd1 << 23)) >> 24;
                if (mag == 0) neg = 1'b0;
            end
        end
        if (res.status != ST_OK) begin
            res.score = '0;
        end else if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            res.score = 32'((64'h1_0000_0000 - mag) & 64'hFFFF_FFFF);
        end else begin
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            res.score = 32'(mag);
        end
        return res;
    endfunction

    // Offer one posting and hold it until accepted; bursts end in random gaps.
    task automatic send_posting(longint unsigned ft, longint unsigned fdt, longint unsigned dlen);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, dlen[CW-1:0], fdt[CW-1:0], ft[CW-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_scores.insert(expected_scores.size(),
                               bm25_score_of(ft & CNT_MASK, fdt & CNT_MASK, dlen & CNT_MASK));
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 60);
        end else begin
            burst_left--;
        end
    endtask

    // Let every word in flight come out before touching the registers.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        wait (expected_scores.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DOC_COUNT:  n_docs = value & CNT_MASK;
            CFG_AVG_LENGTH: avg_len = value & CNT_MASK;
            CFG_K1_GAIN:    k1_q12 = value[15:0];
            CFG_B_WEIGHT:   b_q15 = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] n, logic [31:0] avg, logic [31:0] k1, logic [31:0] b);
        drain();
        write_reg(CFG_DOC_COUNT, n);
        write_reg(CFG_AVG_LENGTH, avg);
        write_reg(CFG_K1_GAIN, k1);
        write_reg(CFG_B_WEIGHT, b);
    endtask

    // Counts spread over zero, small, medium, fully random and the top of the range.
    function automatic longint unsigned pick_count();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(1, 20);
            2: return $urandom_range(1, 5000);
            3: return $urandom() & CNT_MASK;
            4: return CNT_MAX;
            default: return CNT_MAX - $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic longint unsigned pick_ft();
        if (n_docs != 0 && $urandom_range(0, 3) != 0) begin
            return $urandom_range(0, 32'(n_docs));
        end
        return pick_count();
    endfunction

    // Registers at reset: zero average length flags every posting.
    task automatic test_reset_defaults();
        n_docs = 0;
        avg_len = 0;
        k1_q12 = 4915;
        b_q15 = 24576;
        send_posting(0, 0, 0);
        send_posting(5, 3, 100);
        send_posting(CNT_MAX, CNT_MAX, CNT_MAX);
    endtask

    // Field extremes, both idf signs and each error case.
    task automatic test_directed();
        set_regs(1000, 100, 4915, 24576);
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        send_posting(0, 1, 100);
        send_posting(1000, 1, 100);
        send_posting(1001, 1, 100);
        send_posting(500, 7, 100);
        send_posting(3, 2, 50);
        send_posting(990, 5, 300);
        send_posting(10, 0, 100);
        send_posting(10, 4, 0);
        send_posting(10, 4, CNT_MAX);
        send_posting(10, CNT_MAX, 100);
        send_posting(CNT_MAX, CNT_MAX, CNT_MAX);
        // Zero denominator through k1 = 0, then through b = 1 and dlen = 0.
        set_regs(32'hFFFF_FFFF, 1, 0, 32768);
        send_posting(0, 0, 0);
        send_posting(0, 1, 0);
        send_posting(CNT_MAX, 3, CNT_MAX);
        drain();
        write_reg(CFG_K1_GAIN, 65535);
        send_posting(0, 0, 0);
        send_posting(0, CNT_MAX, CNT_MAX);
        send_posting(1, CNT_MAX, 1);
        drain();
        write_reg(CFG_B_WEIGHT, 0);
        send_posting(0, 0, 0);
        send_posting(CNT_MAX / 2, 9, 1);
        drain();
        write_reg(CFG_AVG_LENGTH, 32'hFFFF_FFFF);
        send_posting(0, 1, CNT_MAX);
        send_posting(CNT_MAX, 1, 1);
    endtask

    // Long output stall while postings keep coming, so the input backs up.
    task automatic test_backpressure();
        set_regs(100000, 250, 4915, 24576);
        hold_req = 1'b1;
        for (int i = 0; i < 160; i++) send_posting(pick_ft(), pick_count(), pick_count());
    endtask

    // Random postings over a series of register settings.
    task automatic test_random_phases();
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_regs(32'h7FFF_FFFF, 1, 65535, 32768);
                1: set_regs(0, 32'h7FFF_FFFF, 0, 0);
                2: set_regs(1, 1, 4096, 16384);
                3: set_regs(32'hFFFF_FFFF, 500, 4915, 24576);
                default: set_regs($urandom(), 32'(pick_count()), $urandom(),
                                  $urandom_range(0, 32768) | ($urandom() & 32'hFFFF_0000));
            endcase
            for (int i = 0; i < 210; i++) send_posting(pick_ft(), pick_count(), pick_count());
        end
    endtask

    // Long hold counted here while the test keeps sending.
    always begin
        @(posedge i_clk iff hold_req);
        long_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold = 1'b0;
        hold_req = 1'b0;
    end

    // Receiver stalls: stretches of always ready, light stalls and heavy stalls.
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        if (long_hold) i_m_axis_tready <= 1'b0;
        else if (stall_mode == 0) i_m_axis_tready <= 1'b1;
        else if (stall_mode == 1) i_m_axis_tready <= ($urandom_range(0, 9) < 7);
        else i_m_axis_tready <= ($urandom_range(0, 3) == 0);
    end

    // Compare each result word with the oldest expected score.
    always @(posedge i_clk) begin
        t_score_rec want, got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.score = o_m_axis_tdata[31:0];
            got.status = o_m_axis_tdata[33:32];
            if (expected_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word %h", o_m_axis_tdata);
            end else begin
                want = expected_scores.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: score exp %h got %h, status exp %0d got %0d",
                                 want.score, got.score, want.status, got.status);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random_phases();
        drain();
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #24_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
